// File: rtl/rgblab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared types and fixed-point constants for the RGB to CIELAB pipeline.
// ----------------------------------------------------------------------------
package rgblab_pkg;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0] lightness;
    logic [15:0] a_axis;
    logic [15:0] b_axis;
  } lab_t;

  typedef logic [15:0] coef_t;

  // sRGB/D65 matrix, Q0.16, row major
  localparam coef_t MAT [0:8] = '{
    16'd27031, 16'd23434, 16'd11825,
    16'd13938, 16'd46868, 16'd4730,
    16'd1267,  16'd7811,  16'd62279
  };

  // register map
  localparam logic [1:0] REG_WHITE_X = 2'd0;
  localparam logic [1:0] REG_WHITE_Y = 2'd1;
  localparam logic [1:0] REG_WHITE_Z = 2'd2;

  localparam logic [16:0] WHITE_X_RST = 17'd62289;
  localparam logic [16:0] WHITE_Y_RST = 17'd65535;
  localparam logic [16:0] WHITE_Z_RST = 17'd71356;

  // stage depths
  localparam int MAT_LAT   = 2;
  localparam int DIV_STEPS = 42;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int CBRT_STEPS = 22;
  localparam int CIE_LAT   = CBRT_STEPS + 1;
  localparam int SCL_LAT   = 4;
  localparam int PIPE_LAT  = MAT_LAT + DIV_LAT + CIE_LAT + SCL_LAT;

  // CIE function
  localparam logic [39:0] RATIO_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] LIN_MAX   = 40'd148586;        // t*24389 <= 216*2^24
  localparam logic [14:0] LIN_MUL   = 15'd24389;
  localparam logic [33:0] LIN_OFS   = 34'd7247782368;    // 432*2^24 + 25056
  localparam logic [28:0] LIN_RCP   = 29'd351057353;     // ceil(2^38/783)

  // output scaling
  localparam logic [32:0]        L_MUL = 33'd116;
  localparam logic signed [34:0] L_OFS = 35'sd16777216;  // 16 * 2^20
  localparam logic [28:0]        L_SAT = 29'd1638400;    // 65536 * 25
  localparam logic [21:0]        L_RCP = 22'd2684355;    // ceil(2^26/25)
  localparam logic signed [46:0] A_MUL = 47'sd163835;
  localparam logic signed [46:0] A_OFS = 47'sd34359738368;
  localparam logic signed [45:0] B_OFS = 46'sd34359738368;

endpackage

// File: rtl/rgb_to_cielab_16bit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cielab_16bit_core
// 16-bit linear RGB to 16-bit CIELAB converter with programmable white.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready channel, one pixel item (red, green, blue).
//   out_*  : valid/ready channel, one Lab item (lightness, a_axis, b_axis).
//   APB    : white_x at 0x0, white_y at 0x4, white_z at 0x8 (17 bits each);
//            write only while no item is in flight. Reads return the value.
// Depth: 72 register stages. Stages: 2 matrix, 43 divider (a rounding
//   stage, then one quotient bit per stage), 23 CIE function (22 cube root
//   digits), 4 scaling, the last being the output register.
// Throughput: one item per cycle unless stalled; nothing links successive pixels.
// Stall: the whole pipeline advances on one enable, which is high while
//   the output register is empty or being taken. When the receiver holds
//   out_ready low with a result waiting, in_ready drops and every stage
//   holds, so no item is lost or repeated.
// Reset: rst_n clears the valid chain and loads the D65 white defaults.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_to_cielab_16bit_core (
  input  logic               clk,
  input  logic               rst_n,
  // pixel in
  input  logic               in_valid,
  output logic               in_ready,
  input  rgblab_pkg::pixel_t in_data,
  // Lab out
  output logic               out_valid,
  input  logic               out_ready,
  output rgblab_pkg::lab_t   out_data,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = rgblab_pkg::PIPE_LAT;

  logic [LAT-1:0] v_r;
  logic [LAT-1:0] v_nxt;
  logic           en;
  logic [16:0]    wx_r, wy_r, wz_r;
  logic [33:0]    sx, sy, sz;
  logic [41:0]    qx, qy, qz;
  logic [25:0]    fx, fy, fz;
  logic [1:0]     reg_idx;

  // ---------------- config registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r <= rgblab_pkg::WHITE_X_RST;
      wy_r <= rgblab_pkg::WHITE_Y_RST;
      wz_r <= rgblab_pkg::WHITE_Z_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rgblab_pkg::REG_WHITE_X: wx_r <= pwdata[16:0];
        rgblab_pkg::REG_WHITE_Y: wy_r <= pwdata[16:0];
        rgblab_pkg::REG_WHITE_Z: wz_r <= pwdata[16:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rgblab_pkg::REG_WHITE_X: prdata = {15'd0, wx_r};
      rgblab_pkg::REG_WHITE_Y: prdata = {15'd0, wy_r};
      rgblab_pkg::REG_WHITE_Z: prdata = {15'd0, wz_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // single enable: advance unless a finished result is held
  assign en        = !v_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[LAT-1];
  assign v_nxt     = {v_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // ---------------- datapath ----------------
  rgblab_matrix u_matrix (
    .clk   (clk),
    .en    (en),
    .pix   (in_data),
    .sum_x (sx),
    .sum_y (sy),
    .sum_z (sz)
  );

  // the user must keep white registers static while items are in flight; the block does not enforce it
  rgblab_div u_div_x (.clk(clk), .en(en), .sum(sx), .white(wx_r), .quo(qx));
  rgblab_div u_div_y (.clk(clk), .en(en), .sum(sy), .white(wy_r), .quo(qy));
  rgblab_div u_div_z (.clk(clk), .en(en), .sum(sz), .white(wz_r), .quo(qz));

  rgblab_cie u_cie_x (.clk(clk), .en(en), .quo(qx), .f(fx));
  rgblab_cie u_cie_y (.clk(clk), .en(en), .quo(qy), .f(fy));
  rgblab_cie u_cie_z (.clk(clk), .en(en), .quo(qz), .f(fz));

  rgblab_scale u_scale (
    .clk (clk),
    .en  (en),
    .fx  (fx),
    .fy  (fy),
    .fz  (fz),
    .res (out_data)
  );

  // ---------------- assertions ----------------
  // a stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid chain moved during stall");

  // a result appears only from the stage ahead of the output register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v_r[LAT-2]))
    else $error("output valid without a feeding item");

  // a bubble ahead of the output register empties it when advancing
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !v_r[LAT-2]) |=> !out_valid)
    else $error("output valid after bubble");

endmodule

// File: rtl/rgblab_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_matrix
// RGB to XYZ matrix: products in one stage, row sums in the next.
// ----------------------------------------------------------------------------
module rgblab_matrix (
  input  logic               clk,
  input  logic               en,
  input  rgblab_pkg::pixel_t pix,
  output logic [33:0]        sum_x,
  output logic [33:0]        sum_y,
  output logic [33:0]        sum_z
);

  logic [15:0] ch [0:2];
  logic [31:0] prod_r [0:8];
  logic [33:0] sx_r, sy_r, sz_r;

  assign ch[0] = pix.red;
  assign ch[1] = pix.green;
  assign ch[2] = pix.blue;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= {16'd0, rgblab_pkg::MAT[i]} * {16'd0, ch[i % 3]};
      end
      sx_r <= 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]);
      sy_r <= 34'(prod_r[3]) + 34'(prod_r[4]) + 34'(prod_r[5]);
      sz_r <= 34'(prod_r[6]) + 34'(prod_r[7]) + 34'(prod_r[8]);
    end
  end

  assign sum_x = sx_r;
  assign sum_y = sy_r;
  assign sum_z = sz_r;

endmodule

// File: rtl/rgblab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_div
// Pipelined restoring divider: Q.24 ratio of a sum to a white value,
// rounded half up, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgblab_div (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] sum,
  input  logic [16:0] white,
  output logic [41:0] quo
);

  localparam int N = rgblab_pkg::DIV_STEPS;

  logic [16:0] w;
  logic [41:0] num_r [0:N];
  logic [16:0] rem_r [0:N];

  // zero white acts as one
  assign w = (white == 17'd0) ? 17'd1 : white;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= {sum, 8'd0} + 42'(w >> 1);
      rem_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [17:0] rem2;
    logic        ge;
    assign rem2 = {rem_r[k-1], num_r[k-1][41]};
    assign ge   = rem2 >= {1'b0, w};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 17'(rem2 - {1'b0, w}) : rem2[16:0];
        num_r[k] <= {num_r[k-1][40:0], ge};
      end
    end
  end

  assign quo = num_r[N];

endmodule

// File: rtl/rgblab_cie.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_cie
// CIE f function: 22-stage digit-by-digit cube root with the linear
// segment computed alongside by reciprocal multiply. Q.24 in, Q.20 out.
// ----------------------------------------------------------------------------
module rgblab_cie (
  input  logic        clk,
  input  logic        en,
  input  logic [41:0] quo,
  output logic [25:0] f
);

  localparam int S = rgblab_pkg::CBRT_STEPS;

  logic [39:0] t;
  logic [65:0] x0_r;
  logic        lin0_r, sh0_r;
  logic [32:0] lp_r;
  logic [56:0] ld_r;

  logic [49:0] r_r   [0:S-1];
  logic [21:0] y_r   [0:S-1];
  logic [43:0] sq_r  [0:S-1];
  logic [65:0] x_r   [0:S-1];
  logic        lin_r [0:S-1];
  logic        sh_r  [0:S-1];
  logic [17:0] lv_r  [1:S-1];

  // saturate huge ratios
  assign t = (quo[41:40] != 2'b00) ? rgblab_pkg::RATIO_MAX : quo[39:0];

  always_ff @(posedge clk) begin
    if (en) begin
      lin0_r <= t <= rgblab_pkg::LIN_MAX;
      sh0_r  <= t[39:28] != 12'd0;
      x0_r   <= (t[39:28] != 12'd0) ? {2'b00, t, 24'd0} : {2'b00, t[27:0], 36'd0};
      lp_r   <= 33'(t[17:0]) * 33'(rgblab_pkg::LIN_MUL);
    end
  end

  for (genvar j = 0; j < S; j++) begin : g_root
    logic [49:0] r_in;
    logic [21:0] y_in;
    logic [43:0] sq_in;
    logic [65:0] x_in;
    logic        lin_in, sh_in;
    logic [21:0] y2;
    logic [43:0] sq2;
    logic [49:0] r3, b;
    logic        ge;

    if (j == 0) begin : g_first
      assign r_in   = '0;
      assign y_in   = '0;
      assign sq_in  = '0;
      assign x_in   = x0_r;
      assign lin_in = lin0_r;
      assign sh_in  = sh0_r;
    end else begin : g_next
      assign r_in   = r_r[j-1];
      assign y_in   = y_r[j-1];
      assign sq_in  = sq_r[j-1];
      assign x_in   = x_r[j-1];
      assign lin_in = lin_r[j-1];
      assign sh_in  = sh_r[j-1];
    end

    // b = 3*y2^2 + 3*y2 + 1 with y2 = 2*y
    assign y2  = {y_in[20:0], 1'b0};
    assign sq2 = {sq_in[41:0], 2'b00};
    assign b   = 50'(sq2) + 50'({sq2, 1'b0}) + 50'(y2) + 50'({y2, 1'b0}) + 50'd1;
    assign r3  = {r_in[46:0], x_in[65:63]};
    assign ge  = r3 >= b;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j]   <= ge ? r3 - b : r3;
        y_r[j]   <= {y2[21:1], ge};
        sq_r[j]  <= ge ? sq2 + 44'({y2, 1'b0}) + 44'd1 : sq2;
        x_r[j]   <= {x_in[62:0], 3'b000};
        lin_r[j] <= lin_in;
        sh_r[j]  <= sh_in;
      end
    end

    if (j == 0) begin : g_lmul
      logic [33:0] lsum;
      assign lsum = 34'(lp_r) + rgblab_pkg::LIN_OFS;
      always_ff @(posedge clk) begin
        if (en) begin
          // floor(n/50112) = floor(floor(n/64)/783)
          ld_r <= 57'(lsum[33:6]) * 57'(rgblab_pkg::LIN_RCP);
        end
      end
    end else if (j == 1) begin : g_lshift
      always_ff @(posedge clk) begin
        if (en) begin
          lv_r[j] <= ld_r[55:38];
        end
      end
    end else begin : g_ldly
      always_ff @(posedge clk) begin
        if (en) begin
          lv_r[j] <= lv_r[j-1];
        end
      end
    end
  end

  assign f = lin_r[S-1] ? 26'(lv_r[S-1]) :
             sh_r[S-1]  ? {y_r[S-1], 4'd0} : {4'd0, y_r[S-1]};

endmodule

// File: rtl/rgblab_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_scale
// Forms L*, a*, b*, scales, clamps and truncates to 16 bits (4 stages).
// The last stage is the output register.
// ----------------------------------------------------------------------------
module rgblab_scale (
  input  logic             clk,
  input  logic             en,
  input  logic [25:0]      fx,
  input  logic [25:0]      fy,
  input  logic [25:0]      fz,
  output rgblab_pkg::lab_t res
);

  logic [32:0]        fy116;
  logic signed [34:0] dl_r;
  logic signed [26:0] da_r, db_r;
  logic signed [50:0] nl_r;
  logic signed [46:0] na_r;
  logic signed [45:0] nb_r;
  logic [28:0]        nls;
  logic [42:0]        lp_r;
  logic               lz_r, ls_r;
  logic [15:0]        a_r, b_r;
  rgblab_pkg::lab_t   res_r;

  assign fy116 = 33'(fy) * rgblab_pkg::L_MUL;
  assign nls   = nl_r[50:22];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: differences
      dl_r <= $signed({2'b00, fy116}) - rgblab_pkg::L_OFS;
      da_r <= $signed({1'b0, fx}) - $signed({1'b0, fy});
      db_r <= $signed({1'b0, fy}) - $signed({1'b0, fz});
      // stage B: scale
      nl_r <= (51'(dl_r) <<< 16) - 51'(dl_r);
      na_r <= 47'(da_r) * rgblab_pkg::A_MUL + rgblab_pkg::A_OFS;
      nb_r <= (46'(db_r) <<< 16) - (46'(db_r) <<< 1) + rgblab_pkg::B_OFS;
      // stage C: clamp, L divide by 100*2^20 as >>22 then /25
      lz_r <= nl_r[50] || (nl_r == '0);
      ls_r <= nls >= rgblab_pkg::L_SAT;
      lp_r <= 43'((nls >= rgblab_pkg::L_SAT) ? 21'd0 : nls[20:0]) *
              43'(rgblab_pkg::L_RCP);
      if (na_r[46] || na_r == '0) begin
        a_r <= '0;
      end else if (na_r[45:36] != '0) begin
        a_r <= 16'hFFFF;
      end else begin
        a_r <= na_r[35:20];
      end
      if (nb_r[45] || nb_r == '0) begin
        b_r <= '0;
      end else if (nb_r[44:36] != '0) begin
        b_r <= 16'hFFFF;
      end else begin
        b_r <= nb_r[35:20];
      end
      // stage D: output register
      res_r.lightness <= lz_r ? 16'd0 : (ls_r ? 16'hFFFF : lp_r[41:26]);
      res_r.a_axis    <= a_r;
      res_r.b_axis    <= b_r;
    end
  end

  assign res = res_r;

endmodule

// File: tb/rgb_to_cielab_16bit_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cielab_16bit_core_checker
// Watches the pixel, Lab and register ports. Tracks the white registers,
// predicts each Lab item from the accepted pixel, compares in order.
// ----------------------------------------------------------------------------
module rgb_to_cielab_16bit_core_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rgblab_pkg::pixel_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rgblab_pkg::lab_t   out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 waiting,
  output int                 checked
);

  typedef longint unsigned u64_t;

  // matrix coefficients, 7 decimal digits, rounded to Q0.16 below
  localparam longint unsigned MAT_E7 [0:8] = '{
    4124564, 3575761, 1804375,
    2126729, 7151522, 721750,
    193339,  1191920, 9503041
  };

  logic [16:0]      wx, wy, wz;
  rgblab_pkg::lab_t lab_due[$];

  function automatic u64_t coef_q16(int k);
    return (MAT_E7[k] * 65536 + 5000000) / 10000000;
  endfunction

  // digit-by-digit cube root, 22 steps of 3 bits
  function automatic u64_t cube_root(u64_t x);
    u64_t y, b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  // Q.16 sum over white -> Q.24, rounded half up, saturated at 2^40-1
  function automatic u64_t white_ratio(u64_t sum, logic [16:0] w_reg);
    u64_t w, t;
    w = (w_reg == 0) ? 1 : u64_t'(w_reg);
    t = (sum * 256 + w / 2) / w;
    if (t > 64'hFF_FFFF_FFFF) t = 64'hFF_FFFF_FFFF;
    return t;
  endfunction

  // CIE f, Q.24 in, Q.20 out
  function automatic u64_t cie_curve(u64_t t);
    if (t * 24389 > (u64_t'(216) << 24)) begin
      if (t < (u64_t'(1) << 28)) return cube_root(t << 36);
      return cube_root(t << 24) << 4;
    end
    return (24389 * t + (u64_t'(432) << 24) + 25056) / 50112;
  endfunction

  function automatic logic [15:0] clamp_quot(longint n, longint d);
    longint q;
    if (n <= 0) return 16'd0;
    q = n / d;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic rgblab_pkg::lab_t lab_of(rgblab_pkg::pixel_t p);
    u64_t             ch [0:2];
    u64_t             s  [0:2];
    longint           fx, fy, fz, one;
    rgblab_pkg::lab_t r;
    ch[0] = u64_t'(p.red);
    ch[1] = u64_t'(p.green);
    ch[2] = u64_t'(p.blue);
    for (int i = 0; i < 3; i++) begin
      s[i] = 0;
      for (int j = 0; j < 3; j++) s[i] += coef_q16(3 * i + j) * ch[j];
    end
    fx  = longint'(cie_curve(white_ratio(s[0], wx)));
    fy  = longint'(cie_curve(white_ratio(s[1], wy)));
    fz  = longint'(cie_curve(white_ratio(s[2], wz)));
    one = 64'd1 << 20;
    r.lightness = clamp_quot(65535 * (116 * fy - 16 * one), 100 * one);
    r.a_axis    = clamp_quot(163835 * (fx - fy) + 32768 * one, one);
    r.b_axis    = clamp_quot(65534 * (fy - fz) + 32768 * one, one);
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("MISMATCH %s: expected %0d got %0d (result %0d)", what, exp_v, got_v, checked);
    errors++;
  endtask

  initial begin
    errors  = 0;
    waiting = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    rgblab_pkg::lab_t want;
    if (!rst_n) begin
      wx = rgblab_pkg::WHITE_X_RST;
      wy = rgblab_pkg::WHITE_Y_RST;
      wz = rgblab_pkg::WHITE_Z_RST;
      lab_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          rgblab_pkg::REG_WHITE_X: wx = pwdata[16:0];
          rgblab_pkg::REG_WHITE_Y: wy = pwdata[16:0];
          rgblab_pkg::REG_WHITE_Z: wz = pwdata[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) lab_due.push_back(lab_of(in_data));
      if (out_valid && out_ready) begin
        if (lab_due.size() == 0) begin
          report_mismatch("unexpected item, lightness", -1, out_data.lightness);
        end else begin
          want = lab_due.pop_front();
          if (out_data.lightness !== want.lightness)
            report_mismatch("lightness", want.lightness, out_data.lightness);
          if (out_data.a_axis !== want.a_axis)
            report_mismatch("a_axis", want.a_axis, out_data.a_axis);
          if (out_data.b_axis !== want.b_axis)
            report_mismatch("b_axis", want.b_axis, out_data.b_axis);
        end
        checked++;
      end
    end
    waiting = lab_due.size();
  end

endmodule

// File: tb/rgb_to_cielab_16bit_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cielab_16bit_core_test
// Drives pixels and white-register writes into the RGB to Lab core with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rgb_to_cielab_16bit_core_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = rgblab_pkg::PIPE_LAT + 20;  // block latency plus margin

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rgblab_pkg::pixel_t in_data;
  logic               out_valid;
  logic               out_ready;
  rgblab_pkg::lab_t   out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int waiting;
  int checked;
  int cycles;
  int sent;
  int settings;
  bit steady;   // when set, neither side idles

  rgb_to_cielab_16bit_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rgb_to_cielab_16bit_core_checker lab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .waiting  (waiting),
    .checked  (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: sized for the slowest legal run with both sides stalling.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still due", cycles, waiting);
      $display("rgb_to_cielab_16bit_core test failed");
      $finish;
    end
  end

  // Result side: random stall before taking each item. A zero stall leaves
  // out_ready high, so back-to-back takes happen with no extra toggling.
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = steady ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One pixel item: hold valid and data until taken, then maybe a gap.
  // With no gap valid stays high, so the next item raises nothing twice.
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    int gap;
    in_valid      <= 1'b1;
    in_data.red   <= r;
    in_data.green <= g;
    in_data.blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted item has come out, then let the
  // pipe settle for its full latency.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle (pready is tied high).
  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_white(logic [16:0] x, logic [16:0] y, logic [16:0] z);
    drain();
    write_reg({rgblab_pkg::REG_WHITE_X, 2'b00}, {15'd0, x});
    write_reg({rgblab_pkg::REG_WHITE_Y, 2'b00}, {15'd0, y});
    write_reg({rgblab_pkg::REG_WHITE_Z, 2'b00}, {15'd0, z});
    settings++;
  endtask

  // Random pixel mix: full range, dark pixels near the linear knee,
  // saturated channels, single-channel pixels and near-gray pixels.
  task automatic random_pixels(int n);
    logic [15:0] c [0:2];
    for (int k = 0; k < n; k++) begin
      if (k % 97 == 0) steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0, 1: for (int i = 0; i < 3; i++) c[i] = 16'($urandom_range(0, 65535));
        2:    for (int i = 0; i < 3; i++) c[i] = 16'($urandom_range(0, 400));
        3:    for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        4: begin
          for (int i = 0; i < 3; i++) c[i] = 16'h0000;
          c[$urandom_range(0, 2)] = 16'($urandom_range(0, 65535));
        end
        default: begin
          // near-gray, so a and b sit around the midpoint
          c[0] = 16'($urandom_range(0, 65535));
          c[1] = c[0] ^ 16'($urandom_range(0, 255));
          c[2] = c[0] ^ 16'($urandom_range(0, 255));
        end
      endcase
      send_pixel(c[0], c[1], c[2]);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    sent     = 0;
    settings = 0;
    steady   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset white, then edges of the channels and the knee.
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0001, 16'h0001, 16'h0001);
    send_pixel(16'd580, 16'd580, 16'd580);   // just around the linear knee
    send_pixel(16'd581, 16'd581, 16'd581);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(16'h8000, 16'h7FFF, 16'h0001);

    // Tiny white: ratios saturate before the cube root.
    set_white(17'd1, 17'd1, 17'd1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0001, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000);

    // Zero white behaves like one.
    set_white(17'd0, 17'd0, 17'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'h0001, 16'h0000);

    // Largest white: every ratio stays below one.
    set_white(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    random_pixels(250);

    // Write above the map must not touch any register.
    set_white(17'd62289, 17'd65535, 17'd71356);
    write_reg(4'hC, 32'h0000_0001);
    random_pixels(530);

    set_white(17'd1, 17'd1, 17'd1);
    random_pixels(150);

    set_white(17'd0, 17'd0, 17'd0);
    random_pixels(150);

    set_white(17'd96422, 17'd100000, 17'd82521);
    random_pixels(200);
    drain();   // sender holds until every result is back
    random_pixels(200);

    for (int p = 0; p < 3; p++) begin
      set_white(17'($urandom_range(1, 131071)), 17'($urandom_range(1, 131071)),
                17'($urandom_range(1, 131071)));
      random_pixels(100);
    end
    set_white(17'($urandom_range(1, 31)), 17'($urandom_range(1, 31)),
              17'($urandom_range(1, 31)));
    random_pixels(100);

    drain();
    $display("covered %0d pixels under %0d white settings, %0d Lab items compared",
             sent, settings, checked);
    $display("white extremes, zero white, saturated ratios and a stray write included");
    if (errors == 0) begin
      $display("rgb_to_cielab_16bit_core test passed");
    end else begin
      $display("rgb_to_cielab_16bit_core test failed");
    end
    $finish;
  end

endmodule
